### sv/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg
// Shared types and constants of the square matrix multiply block.
// ----------------------------------------------------------------------------
package smm_pkg;

   localparam int MAX_SIZE_DEFAULT      = 16;
   localparam int ELEMENT_WIDTH_DEFAULT = 16;

   localparam int IDX_W   = 4;
   localparam int SIZE_W  = 5;
   localparam int FUNC_W  = 2;
   localparam int VALUE_W = 32;
   localparam int ELEM_IN_W = 16;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
   localparam int SIZE_LIMIT = 16;

   localparam logic [FUNC_W-1:0] FUNC_WRITE_A = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE_B = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = 2;
   localparam int CMD_CNT_W = 3;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef struct packed {
      logic                      is_compute;
      logic                      sel_b;
      logic [IDX_W-1:0]          row;
      logic [IDX_W-1:0]          col;
      logic signed [VALUE_W-1:0] value;
   } smm_cmd_type;

   typedef struct packed {
      logic [IDX_W-1:0]          row;
      logic [IDX_W-1:0]          col;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } smm_rsp_type;

endpackage

### sv/smm_front.sv
// ----------------------------------------------------------------------------
// smm_front
// Accepts request items, drops those with no effect and queues the rest
// as commands for the compute side.
// ----------------------------------------------------------------------------
module smm_front #(
   parameter int MAX_SIZE = smm_pkg::MAX_SIZE_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [smm_pkg::FUNC_W-1:0]          req_func,
   input  logic [smm_pkg::IDX_W-1:0]           req_row_index,
   input  logic [smm_pkg::IDX_W-1:0]           req_col_index,
   input  logic signed [smm_pkg::ELEM_IN_W-1:0] req_element_value,
   input  logic [smm_pkg::SIZE_W-1:0]          active_size,
   output logic                                cmd_valid,
   output smm_pkg::smm_cmd_type                cmd,
   input  logic                                cmd_pop
);
   import smm_pkg::*;

   smm_cmd_type          queue_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;

   logic        is_write;
   logic        in_store;
   logic        is_comp;
   logic        enq;
   smm_cmd_type new_cmd;

   always_comb begin
      is_write = (req_func == FUNC_WRITE_A) || (req_func == FUNC_WRITE_B);
      in_store = (int'(req_row_index) < MAX_SIZE) && (int'(req_col_index) < MAX_SIZE);
      is_comp  = (req_func == FUNC_COMPUTE) && (SIZE_W'(req_row_index) < active_size);
      full     = (count_ff == CMD_CNT_W'(CMD_DEPTH));
      enq      = push && !full && ((is_write && in_store) || is_comp);

      new_cmd.is_compute = is_comp;
      new_cmd.sel_b      = (req_func == FUNC_WRITE_B);
      new_cmd.row        = req_row_index;
      new_cmd.col        = req_col_index;
      new_cmd.value      = VALUE_W'(req_element_value);

      cmd_valid = (count_ff != '0);
      cmd       = queue_ff[rd_ptr_ff];

      wr_ptr_in = enq ? wr_ptr_ff + CMD_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + CMD_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (enq && !cmd_pop) begin
         count_in = count_ff + CMD_CNT_W'(1);
      end else if (!enq && cmd_pop) begin
         count_in = count_ff - CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/smm_back.sv
// ----------------------------------------------------------------------------
// smm_back
// Holds the operand stores, applies element writes and runs the shared
// multiply-accumulate pipeline over one row of the product.
// ----------------------------------------------------------------------------
module smm_back #(
   parameter int MAX_SIZE      = smm_pkg::MAX_SIZE_DEFAULT,
   parameter int ELEMENT_WIDTH = smm_pkg::ELEMENT_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [smm_pkg::SIZE_W-1:0]    active_size,
   input  logic                          cmd_valid,
   input  smm_pkg::smm_cmd_type          cmd,
   output logic                          cmd_pop,
   input  logic [smm_pkg::RSP_CNT_W-1:0] rsp_count,
   output logic                          rsp_push,
   output smm_pkg::smm_rsp_type          rsp
);
   import smm_pkg::*;

   localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
   localparam int AW_RAW = $clog2(DEPTH);
   localparam int AW     = (AW_RAW < 1) ? 1 : AW_RAW;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } back_state_type;

   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last;
      logic             last_col;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } beat_type;

   logic signed [ELEMENT_WIDTH-1:0] a_mem [DEPTH];
   logic signed [ELEMENT_WIDTH-1:0] b_mem [DEPTH];
   logic signed [ELEMENT_WIDTH-1:0] a_rd_ff;
   logic signed [ELEMENT_WIDTH-1:0] b_rd_ff;

   back_state_type   state_ff, state_in;
   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;

   beat_type s1_ff, s1_in;
   beat_type s2_ff;
   beat_type s3_ff;

   logic signed [VALUE_W-1:0] a_ext;
   logic signed [VALUE_W-1:0] b_ext;
   logic signed [VALUE_W-1:0] prod_ff, prod_in;
   logic signed [VALUE_W-1:0] acc_ff, acc_in;

   logic                 k_last;
   logic                 j_last;
   logic [RSP_CNT_W-1:0] pending;
   logic                 credit_ok;
   logic                 issue;
   logic                 wr_a;
   logic                 wr_b;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        a_addr;
   logic [AW-1:0]        b_addr;

   always_comb begin
      k_last  = (SIZE_W'(k_ff) + SIZE_W'(1)) == active_size;
      j_last  = (SIZE_W'(j_ff) + SIZE_W'(1)) == active_size;
      pending = rsp_count
              + RSP_CNT_W'(s1_ff.valid && s1_ff.last)
              + RSP_CNT_W'(s2_ff.valid && s2_ff.last)
              + RSP_CNT_W'(s3_ff.valid && s3_ff.last);
      credit_ok = !k_last || (pending < RSP_CNT_W'(RSP_DEPTH));
      issue     = (state_ff == ST_RUN) && credit_ok;

      cmd_pop = (state_ff == ST_IDLE) && cmd_valid;
      wr_a    = cmd_pop && !cmd.is_compute && !cmd.sel_b;
      wr_b    = cmd_pop && !cmd.is_compute && cmd.sel_b;
      wr_addr = AW'(cmd.row) * AW'(MAX_SIZE) + AW'(cmd.col);
      a_addr  = AW'(row_ff) * AW'(MAX_SIZE) + AW'(k_ff);
      b_addr  = AW'(k_ff) * AW'(MAX_SIZE) + AW'(j_ff);

      state_in = state_ff;
      row_in   = row_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_pop && cmd.is_compute) begin
               state_in = ST_RUN;
               row_in   = cmd.row;
               j_in     = '0;
               k_in     = '0;
            end
         end
         ST_RUN: begin
            if (issue) begin
               if (k_last) begin
                  k_in = '0;
                  j_in = j_ff + IDX_W'(1);
                  if (j_last) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  k_in = k_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      s1_in.valid    = issue;
      s1_in.first    = (k_ff == '0);
      s1_in.last     = k_last;
      s1_in.last_col = j_last;
      s1_in.row      = row_ff;
      s1_in.col      = j_ff;

      a_ext   = VALUE_W'(a_rd_ff);
      b_ext   = VALUE_W'(b_rd_ff);
      prod_in = a_ext * b_ext;

      acc_in = acc_ff;
      if (s2_ff.valid) begin
         acc_in = s2_ff.first ? prod_ff : acc_ff + prod_ff;
      end

      rsp_push  = s3_ff.valid && s3_ff.last;
      rsp.row   = s3_ff.row;
      rsp.col   = s3_ff.col;
      rsp.value = acc_ff;
      rsp.last  = s3_ff.last_col;
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         a_mem[wr_addr] <= cmd.value[ELEMENT_WIDTH-1:0];
      end
      a_rd_ff <= a_mem[a_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         b_mem[wr_addr] <= cmd.value[ELEMENT_WIDTH-1:0];
      end
      b_rd_ff <= b_mem[b_addr];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         s1_ff    <= '0;
         s2_ff    <= '0;
         s3_ff    <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         s1_ff    <= s1_in;
         s2_ff    <= s1_ff;
         s3_ff    <= s2_ff;
      end
   end

endmodule

### sv/smm_rsp_queue.sv
// ----------------------------------------------------------------------------
// smm_rsp_queue
// Result queue between the compute pipeline and the response port.
// ----------------------------------------------------------------------------
module smm_rsp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rsp_push,
   input  smm_pkg::smm_rsp_type          rsp_in,
   input  logic                          pop,
   output logic                          empty,
   output smm_pkg::smm_rsp_type          rsp_out,
   output logic [smm_pkg::RSP_CNT_W-1:0] count
);
   import smm_pkg::*;

   smm_rsp_type          queue_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 deq;

   always_comb begin
      empty   = (count_ff == '0);
      count   = count_ff;
      rsp_out = queue_ff[rd_ptr_ff];
      deq     = pop && !empty;

      wr_ptr_in = rsp_push ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = deq ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (rsp_push && !deq) begin
         count_in = count_ff + RSP_CNT_W'(1);
      end else if (!rsp_push && deq) begin
         count_in = count_ff - RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         queue_ff[wr_ptr_ff] <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/square_matrix_multiply.sv
// ----------------------------------------------------------------------------
// square_matrix_multiply
// Integer product C = A x B, one row of C per compute item, through one
// shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Load item: written to its operand store as the back end takes it; the
// first result of a row passes the read, product and accumulate registers.
// Compute item: one MAC step per cycle while the result queue has room, set by
// the single read port of each operand store and the single MAC.
// Reset (synchronous): queues empty, matrix_size back to 16; operand
// stores keep whatever they hold until written.
// ----------------------------------------------------------------------------
module square_matrix_multiply #(
   parameter int MAX_SIZE      = smm_pkg::MAX_SIZE_DEFAULT,
   parameter int ELEMENT_WIDTH = smm_pkg::ELEMENT_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic [smm_pkg::FUNC_W-1:0]           req_func,
   input  logic [smm_pkg::IDX_W-1:0]            req_row_index,
   input  logic [smm_pkg::IDX_W-1:0]            req_col_index,
   input  logic signed [smm_pkg::ELEM_IN_W-1:0] req_element_value,
   output logic                                 empty,
   input  logic                                 pop,
   output logic [smm_pkg::IDX_W-1:0]            rsp_out_row,
   output logic [smm_pkg::IDX_W-1:0]            rsp_out_col,
   output logic signed [smm_pkg::VALUE_W-1:0]   rsp_product_value,
   output logic                                 rsp_last_flag,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [smm_pkg::SIZE_W-1:0]           csr_matrix_size
);
   import smm_pkg::*;

   localparam int SIZE_CAP = (MAX_SIZE < SIZE_LIMIT) ? MAX_SIZE : SIZE_LIMIT;

   logic [SIZE_W-1:0]    matrix_size_ff, matrix_size_in;
   logic [SIZE_W-1:0]    active_size;
   logic                 cmd_valid;
   smm_cmd_type          cmd;
   logic                 cmd_pop;
   logic                 rsp_push;
   smm_rsp_type          rsp_new;
   smm_rsp_type          rsp_head;
   logic [RSP_CNT_W-1:0] rsp_count;

   always_comb begin
      csr_ready      = 1'b1;
      matrix_size_in = (csr_valid && csr_ready) ? csr_matrix_size : matrix_size_ff;
      if (matrix_size_ff == '0) begin
         active_size = SIZE_W'(1);
      end else if (matrix_size_ff > SIZE_W'(SIZE_CAP)) begin
         active_size = SIZE_W'(SIZE_CAP);
      end else begin
         active_size = matrix_size_ff;
      end
      rsp_out_row       = rsp_head.row;
      rsp_out_col       = rsp_head.col;
      rsp_product_value = rsp_head.value;
      rsp_last_flag     = rsp_head.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_size_ff <= SIZE_RESET;
      end else begin
         matrix_size_ff <= matrix_size_in;
      end
   end

   smm_front #(
      .MAX_SIZE (MAX_SIZE)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_func          (req_func),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_element_value (req_element_value),
      .active_size       (active_size),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_pop           (cmd_pop)
   );

   smm_back #(
      .MAX_SIZE      (MAX_SIZE),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .active_size (active_size),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .rsp_count   (rsp_count),
      .rsp_push    (rsp_push),
      .rsp         (rsp_new)
   );

   smm_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .rsp_push (rsp_push),
      .rsp_in   (rsp_new),
      .pop      (pop),
      .empty    (empty),
      .rsp_out  (rsp_head),
      .count    (rsp_count)
   );

   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (rsp_count < RSP_CNT_W'(RSP_DEPTH)))
      else $error("result queue written while full");

   a_last_on_final_col: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_last_flag) |-> ((SIZE_W'(rsp_out_col) + SIZE_W'(1)) == active_size))
      else $error("last flag away from final column");

   a_rsp_in_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((SIZE_W'(rsp_out_col) < active_size) && (SIZE_W'(rsp_out_row) < active_size)))
      else $error("result index outside active size");

endmodule
